@@ design/mpr_pkg.sv @@
// Shared types and constants for the MRU page replacement block.
// No dependencies; used by the controller, datapath, register port and top.
`default_nettype none

package mpr_pkg;

    // Fixed port widths
    localparam int PAGE_PORT_W = 16;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = 32;
    localparam int FIU_W       = 5;
    // Width that holds the 5-bit frame count and any frame total up to 64
    localparam int NUM_W       = 7;

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd3;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_COMPARE = 3'b010,
        ST_UPDATE  = 3'b100
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // latch the incoming page
        logic compare;  // register match / empty vectors
        logic update;   // pick frame, write store, bump counters
    } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ design/mru_page_replacement_top.sv @@
// Top level of the MRU page replacement block: register port, controller, datapath.
// Depends on mpr_pkg, mpr_apb, mpr_ctrl and mpr_dp.
//
//  channel   handshake                    payload
//  -------   --------------------------   ---------------------------------------
//  input     start & !busy                page_number[15:0]
//  result    done (one cycle)             hit, frame_slot, evicted_valid,
//                                         evicted_page, fault_total, hit_total
//  config    psel & penable & pwrite      paddr[2:0], pwdata[31:0] (frames_in_use @ 0)
//
// Each page is compared against all frames in parallel, then an update picks the frame
// and writes the store and counters. busy is high only in the compare cycle, so a new
// item can be accepted during the update of the last one. done and the result
// fields appear the cycle after the update. Reset empties all frames and clears the
// counters; frames_in_use resets to 3. The receiver cannot stall the result.
`default_nettype none

module mru_page_replacement_top
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [mpr_pkg::PAGE_PORT_W-1:0]   page_number,
    output logic                                   done,
    output logic                                   hit,
    output logic      [mpr_pkg::SLOT_W-1:0]        frame_slot,
    output logic                                   evicted_valid,
    output logic      [mpr_pkg::PAGE_PORT_W-1:0]   evicted_page,
    output logic      [mpr_pkg::CNT_W-1:0]         fault_total,
    output logic      [mpr_pkg::CNT_W-1:0]         hit_total,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [mpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [mpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);

    mpr_pkg::ctrl_cmd_t        cmd;
    logic [mpr_pkg::FIU_W-1:0] frames_in_use;

    mpr_apb u_apb
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .frames_in_use (frames_in_use)
    );

    mpr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    mpr_dp
    #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .frames_in_use (frames_in_use),
        .page_number   (page_number),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .hit_total     (hit_total)
    );

endmodule

`default_nettype wire

@@ design/mpr_apb.sv @@
// APB-style register port holding the frames_in_use setting.
// Depends on mpr_pkg.
`default_nettype none

module mpr_apb
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mpr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [mpr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [mpr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output logic      [mpr_pkg::FIU_W-1:0]        frames_in_use
);

    logic [mpr_pkg::FIU_W-1:0] fiu_reg;
    logic [mpr_pkg::FIU_W-1:0] fiu_next;
    logic                      sel_fiu;

    assign pready  = 1'b1;
    assign sel_fiu = (paddr[mpr_pkg::APB_ADDR_W-1:2] == mpr_pkg::REG_FRAMES_IN_USE);

    // Write decode
    always_comb
    begin
        fiu_next = fiu_reg;
        if (psel && penable && pwrite && sel_fiu)
        begin
            fiu_next = pwdata[mpr_pkg::FIU_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg <= mpr_pkg::FIU_RESET;
        end
        else
        begin
            fiu_reg <= fiu_next;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        if (sel_fiu)
        begin
            prdata = mpr_pkg::APB_DATA_W'(fiu_reg);
        end
    end

    assign frames_in_use = fiu_reg;

endmodule

`default_nettype wire

@@ design/mpr_ctrl.sv @@
// Controller state machine: accepts an item, then sequences compare and update.
// Depends on mpr_pkg.
`default_nettype none

module mpr_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output mpr_pkg::ctrl_cmd_t cmd
);

    mpr_pkg::state_t state_reg;
    mpr_pkg::state_t state_next;
    logic            done_reg;
    logic            done_next;
    logic            accept;

    // Busy only during compare; a new item may enter in the update cycle
    assign busy   = (state_reg == mpr_pkg::ST_COMPARE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mpr_pkg::ST_COMPARE;
                end
            end
            mpr_pkg::ST_COMPARE:
            begin
                state_next = mpr_pkg::ST_UPDATE;
            end
            mpr_pkg::ST_UPDATE:
            begin
                if (accept)
                begin
                    state_next = mpr_pkg::ST_COMPARE;
                end
                else
                begin
                    state_next = mpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Result strobe follows the update edge
    assign done_next = (state_reg == mpr_pkg::ST_UPDATE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpr_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign cmd.load    = accept;
    assign cmd.compare = (state_reg == mpr_pkg::ST_COMPARE);
    assign cmd.update  = (state_reg == mpr_pkg::ST_UPDATE);
    assign done        = done_reg;

endmodule

`default_nettype wire

@@ design/mpr_dp.sv @@
// Datapath: frame store, parallel page compare, frame selection and counters.
// Depends on mpr_pkg; driven by commands from mpr_ctrl.
`default_nettype none

module mpr_dp
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mpr_pkg::ctrl_cmd_t                cmd,
    input  wire logic [mpr_pkg::FIU_W-1:0]         frames_in_use,
    input  wire logic [mpr_pkg::PAGE_PORT_W-1:0]   page_number,
    output logic                                   hit,
    output logic      [mpr_pkg::SLOT_W-1:0]        frame_slot,
    output logic                                   evicted_valid,
    output logic      [mpr_pkg::PAGE_PORT_W-1:0]   evicted_page,
    output logic      [mpr_pkg::CNT_W-1:0]         fault_total,
    output logic      [mpr_pkg::CNT_W-1:0]         hit_total
);

    // Stored page width, at most the port width: evicted page bits above it are always zero
    localparam int PW = (PAGE_BITS < mpr_pkg::PAGE_PORT_W) ? PAGE_BITS
                                                           : mpr_pkg::PAGE_PORT_W;
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NW = mpr_pkg::NUM_W;

    // Frame store (no reset) and valid bits
    logic [PW-1:0]              frame_page [FRAMES];
    logic [FRAMES-1:0]          valid_reg;
    logic [FRAMES-1:0]          valid_next;
    logic [FW-1:0]              last_used_reg;
    logic [FW-1:0]              last_used_next;
    logic [mpr_pkg::CNT_W-1:0]  fault_cnt_reg;
    logic [mpr_pkg::CNT_W-1:0]  fault_cnt_next;
    logic [mpr_pkg::CNT_W-1:0]  hit_cnt_reg;
    logic [mpr_pkg::CNT_W-1:0]  hit_cnt_next;

    logic [PW-1:0]              page_reg;
    logic [FRAMES-1:0]          match_reg;
    logic [FRAMES-1:0]          empty_reg;
    logic [FRAMES-1:0]          match_vec;
    logic [FRAMES-1:0]          empty_vec;
    logic [FRAMES-1:0]          active;
    logic [NW-1:0]              n_eff;

    logic                       any_match;
    logic                       any_empty;
    logic [FW-1:0]              match_idx;
    logic [FW-1:0]              empty_idx;
    logic [FW-1:0]              victim_idx;
    logic [FW-1:0]              slot;

    logic                       hit_reg;
    logic [mpr_pkg::SLOT_W-1:0] slot_reg;
    logic                       ev_valid_reg;
    logic [PW-1:0]              ev_page_reg;

    // Effective frame count: zero means one, clamp to FRAMES
    always_comb
    begin
        n_eff = NW'(frames_in_use);
        if (frames_in_use == '0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(frames_in_use) > NW'(FRAMES))
        begin
            n_eff = NW'(FRAMES);
        end
    end

    // Compare every active frame against the page
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            active[i]    = (NW'(i) < n_eff);
            match_vec[i] = active[i] && valid_reg[i] && (frame_page[i] == page_reg);
            empty_vec[i] = active[i] && !valid_reg[i];
        end
    end

    // Input latch and compare vectors
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= page_number[PW-1:0];
        end
        if (cmd.compare)
        begin
            match_reg <= match_vec;
            empty_reg <= empty_vec;
        end
    end

    // Lowest matching frame and lowest empty frame
    always_comb
    begin
        match_idx = '0;
        empty_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                match_idx = FW'(i);
            end
            if (empty_reg[i])
            begin
                empty_idx = FW'(i);
            end
        end
    end

    assign any_match  = |match_reg;
    assign any_empty  = |empty_reg;
    // Replace the most recently used frame, or frame 0 if it is out of range
    assign victim_idx = (NW'(last_used_reg) < n_eff) ? last_used_reg : '0;

    always_comb
    begin
        if (any_match)
        begin
            slot = match_idx;
        end
        else if (any_empty)
        begin
            slot = empty_idx;
        end
        else
        begin
            slot = victim_idx;
        end
    end

    // Next state of valid bits, last-used frame and counters
    always_comb
    begin
        valid_next     = valid_reg;
        last_used_next = last_used_reg;
        fault_cnt_next = fault_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        if (cmd.update)
        begin
            last_used_next = slot;
            if (any_match)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + mpr_pkg::CNT_W'(1);
                end
            end
            else
            begin
                valid_next[slot] = 1'b1;
                if (fault_cnt_reg != '1)
                begin
                    fault_cnt_next = fault_cnt_reg + mpr_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            last_used_reg <= '0;
            fault_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            last_used_reg <= last_used_next;
            fault_cnt_reg <= fault_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
        end
    end

    // Store write and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_reg      <= any_match;
            slot_reg     <= mpr_pkg::SLOT_W'(NW'(slot));
            ev_valid_reg <= !any_match && !any_empty;
            ev_page_reg  <= (!any_match && !any_empty) ? frame_page[victim_idx] : '0;
            if (!any_match)
            begin
                frame_page[slot] <= page_reg;
            end
        end
    end

    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = mpr_pkg::PAGE_PORT_W'(ev_page_reg);
    assign fault_total   = fault_cnt_reg;
    assign hit_total     = hit_cnt_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for mru_page_replacement_top: page references in, result items out.
// Depends on mpr_pkg and the design files; a built-in MRU paging predictor checks every item.

module tb;

    localparam int FRAMES        = 16;
    localparam int PHASE_ITEMS   = 128;
    localparam int SPLIT_A       = 518;
    localparam int SPLIT_B       = 1036;
    localparam int WD_LIMIT      = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    typedef logic [mpr_pkg::PAGE_PORT_W-1:0] page_list_t [$];

    typedef struct {
        logic [mpr_pkg::PAGE_PORT_W-1:0] page;
        bit                              wait_drain;
    } page_ref_t;

    typedef struct packed {
        logic                            hit;
        logic [mpr_pkg::SLOT_W-1:0]      slot;
        logic                            ev_valid;
        logic [mpr_pkg::PAGE_PORT_W-1:0] ev_page;
        logic [mpr_pkg::CNT_W-1:0]       faults;
        logic [mpr_pkg::CNT_W-1:0]       hits;
    } paging_result_t;

    // DUT signals; the inputs are known from time zero
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic [mpr_pkg::PAGE_PORT_W-1:0] page_number = '0;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [mpr_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [mpr_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic                            busy;
    logic                            done;
    logic                            hit;
    logic [mpr_pkg::SLOT_W-1:0]      frame_slot;
    logic                            evicted_valid;
    logic [mpr_pkg::PAGE_PORT_W-1:0] evicted_page;
    logic [mpr_pkg::CNT_W-1:0]       fault_total;
    logic [mpr_pkg::CNT_W-1:0]       hit_total;
    logic [mpr_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    // Predictor state: frame store, MRU frame, counters, frame count register
    logic [mpr_pkg::PAGE_PORT_W-1:0] shadow_page [FRAMES];
    bit                              shadow_valid [FRAMES];
    int                              last_used = 0;
    logic [mpr_pkg::CNT_W-1:0]       model_faults = '0;
    logic [mpr_pkg::CNT_W-1:0]       model_hits = '0;
    logic [mpr_pkg::FIU_W-1:0]       frames_cfg = mpr_pkg::FIU_RESET;

    page_ref_t      pending_refs [$];
    paging_result_t expected_results [$];
    int             items_accepted = 0;
    int             cfg_writes = 0;
    int             failures = 0;
    int             idle_cycles = 0;

    mru_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (16)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .page_number   (page_number),
        .done          (done),
        .hit           (hit),
        .frame_slot    (frame_slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_total   (fault_total),
        .hit_total     (hit_total),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Effective frame count after clamping the register value
    function automatic int active_frames(input logic [mpr_pkg::FIU_W-1:0] cfg);
        int n;
        n = int'(cfg);
        if (n == 0)
            n = 1;
        if (n > FRAMES)
            n = FRAMES;
        return n;
    endfunction

    // MRU paging step: search, fill lowest empty frame, else replace MRU frame
    function automatic paging_result_t model_reference(
        input logic [mpr_pkg::PAGE_PORT_W-1:0] page);
        paging_result_t r;
        int n;
        int slot;
        int empty_slot;
        bit found;
        bit empty_found;
        n = active_frames(frames_cfg);
        slot = 0;
        empty_slot = 0;
        found = 0;
        empty_found = 0;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            if (shadow_valid[i] && shadow_page[i] == page && !found)
            begin
                found = 1;
                slot = i;
            end
            if (!shadow_valid[i] && !empty_found)
            begin
                empty_found = 1;
                empty_slot = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            if (model_hits != '1)
                model_hits = model_hits + 1;
        end
        else
        begin
            if (empty_found)
                slot = empty_slot;
            else
            begin
                // stale MRU index falls back to frame 0
                slot = (last_used < n) ? last_used : 0;
                r.ev_valid = 1'b1;
                r.ev_page = shadow_page[slot];
            end
            shadow_page[slot] = page;
            shadow_valid[slot] = 1;
            if (model_faults != '1)
                model_faults = model_faults + 1;
        end
        last_used = slot;
        r.slot = slot[mpr_pkg::SLOT_W-1:0];
        r.faults = model_faults;
        r.hits = model_hits;
        return r;
    endfunction

    function automatic int sender_idle_pct();
        if (items_accepted < SPLIT_A)
            return 6;
        else if (items_accepted < SPLIT_B)
            return 71;
        return 0;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] FAIL: %s", $realtime, msg);
    endtask

    // Driver: presents the oldest pending page, holds it until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            page_number <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                void'(pending_refs.pop_front());
                expected_results.push_back(model_reference(page_number));
                items_accepted++;
            end
            if (start && busy)
            begin
                // item still waiting for acceptance
            end
            else if (pending_refs.size() > 0
                     && (!pending_refs[0].wait_drain || expected_results.size() == 0)
                     && $urandom_range(99) >= sender_idle_pct())
            begin
                start <= 1'b1;
                page_number <= pending_refs[0].page;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: each result strobe against the oldest expectation
    always @(posedge clk)
    begin : result_check
        paging_result_t want;
        paging_result_t seen;
        if (rst_n && done)
        begin
            seen = '{hit, frame_slot, evicted_valid, evicted_page, fault_total, hit_total};
            if (expected_results.size() == 0)
                note_failure("result strobe with no item outstanding");
            else
            begin
                want = expected_results.pop_front();
                if (seen !== want)
                    note_failure($sformatf(
                        {"want hit=%0d slot=%0d ev=%0d/%h faults=%0d hits=%0d, ",
                         "got hit=%0d slot=%0d ev=%0d/%h faults=%0d hits=%0d"},
                        want.hit, want.slot, want.ev_valid, want.ev_page, want.faults,
                        want.hits, seen.hit, seen.slot, seen.ev_valid, seen.ev_page,
                        seen.faults, seen.hits));
            end
        end
    end

    // Watchdog: cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (psel && penable && pwrite && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("watchdog expired after %0d quiet cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Register write: setup cycle then access cycle, block idle
    task automatic write_frames_cfg(input logic [mpr_pkg::FIU_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {mpr_pkg::REG_FRAMES_IN_USE, 2'b00};
        pwdata <= mpr_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        frames_cfg = value;
        cfg_writes++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_refs.size() != 0 || expected_results.size() != 0 || start);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed(input logic [mpr_pkg::FIU_W-1:0] cfg,
                                input page_list_t pages);
        page_ref_t r;
        write_frames_cfg(cfg);
        @(negedge clk);
        foreach (pages[i])
        begin
            r.page = pages[i];
            r.wait_drain = 0;
            pending_refs.push_back(r);
        end
        wait_drained();
    endtask

    // Mostly references from a small working set, so hits and evictions both occur
    task automatic run_random(input logic [mpr_pkg::FIU_W-1:0] cfg);
        page_ref_t r;
        page_list_t pool;
        write_frames_cfg(cfg);
        pool = {};
        for (int i = 0; i < active_frames(cfg) + 3; i++)
            pool.push_back(mpr_pkg::PAGE_PORT_W'($urandom));
        @(negedge clk);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(99) < 80)
                r.page = pool[$urandom_range(pool.size() - 1)];
            else
                r.page = mpr_pkg::PAGE_PORT_W'($urandom);
            // hold off mid-phase until all results are back
            r.wait_drain = (i == PHASE_ITEMS / 2);
            pending_refs.push_back(r);
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        int cfg_plan [10];
        for (int i = 0; i < FRAMES; i++)
        begin
            shadow_page[i] = '0;
            shadow_valid[i] = 0;
        end
        cfg_plan = '{16, 1, 5, 17, 0, 8, 2, 31, 3, 12};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of the page field, hits, fills and MRU eviction at reset count
        run_directed(5'd3, {16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hABCD,
                            16'hFFFF, 16'h8000});
        // Grow to four frames; leave frame 3 most recently used
        run_directed(5'd4, {16'h0001, 16'h0002, 16'h0000, 16'h0002});
        // Shrink below the MRU frame: replacement falls back to frame 0
        run_directed(5'd2, {16'h7777, 16'h7777});
        // Frame 3 kept its page while outside the active range
        run_directed(5'd4, {16'h0002});
        // Zero frame count acts as one frame
        run_directed(5'd0, {16'h4321, 16'h4321});
        // Oversized count acts as all frames
        run_directed(5'd31, {16'h5A5A, 16'hA5A5, 16'h5A5A});

        foreach (cfg_plan[i])
            run_random(mpr_pkg::FIU_W'(cfg_plan[i]));
        run_random(mpr_pkg::FIU_W'($urandom_range(31)));
        run_random(mpr_pkg::FIU_W'($urandom_range(31)));

        repeat (12) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));

        $display("ran %0d page references across %0d frame-count settings",
                 items_accepted, cfg_writes);
        $display("predicted %0d hits and %0d faults, %0d failures",
                 model_hits, model_faults, failures);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
